// File: hw/rtl/opfrs_pkg.sv
// ----------------------------------------------------------------------------
// opfrs_pkg: shared types and constants of the open-page request scheduler
// Holds queue geometry, stream packing offsets, register indexes and the
// structs that pass between the scheduler and its queue cells.
// ----------------------------------------------------------------------------
package opfrs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PAGE_BITS   = 12;
   localparam int ADDR_WIDTH  = 48;
   localparam int PAGE_WIDTH  = ADDR_WIDTH - PAGE_BITS;
   localparam int TIME_WIDTH  = 32;
   localparam int TAG_WIDTH   = 8;
   localparam int LS_WIDTH    = 8;
   localparam int LAT_WIDTH   = 12;
   localparam int RATIO_WIDTH = 4;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_WIDTH   = $clog2(QUEUE_DEPTH);

   // request tdata layout
   localparam int REQ_TAG_LSB  = ADDR_WIDTH;
   localparam int REQ_HAS_BIT  = REQ_TAG_LSB + TAG_WIDTH;
   localparam int REQ_PF_BIT   = REQ_HAS_BIT + 1;
   localparam int REQ_LS_LSB   = REQ_PF_BIT + 1;
   localparam int REQ_LAT_LSB  = REQ_LS_LSB + LS_WIDTH;
   localparam int REQ_BUS_BIT  = REQ_LAT_LSB + LAT_WIDTH;
   localparam int REQ_BITS     = REQ_BUS_BIT + 1;
   localparam int REQ_TDATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;

   // response tdata layout
   localparam int RSP_ISS_BIT   = 1;
   localparam int RSP_ADDR_LSB  = 2;
   localparam int RSP_RET_BIT   = RSP_ADDR_LSB + ADDR_WIDTH;
   localparam int RSP_TAG_LSB   = RSP_RET_BIT + 1;
   localparam int RSP_PF_BIT    = RSP_TAG_LSB + TAG_WIDTH;
   localparam int RSP_LS_LSB    = RSP_PF_BIT + 1;
   localparam int RSP_CNT_LSB   = RSP_LS_LSB + LS_WIDTH;
   localparam int RSP_BITS      = RSP_CNT_LSB + COUNT_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   // configuration register indexes
   localparam int CSR_ADDR_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = RATIO_WIDTH;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_FIFO_MODE   = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_CLOCK_RATIO = 1'd1;

   // request kinds
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_RETURN,
      ST_RETIRE
   } sched_state_type;

   typedef struct packed {
      logic [ADDR_WIDTH-1:0] addr;
      logic [TAG_WIDTH-1:0]  tag;
      logic                  has_req;
      logic                  prefetch;
      logic [LS_WIDTH-1:0]   line_size;
      logic                  started;
      logic                  returned;
      logic [TIME_WIDTH-1:0] finish;
   } entry_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic issue;
      logic mark_ret;
   } cell_cmd_type;

   typedef struct packed {
      logic unstarted;
      logic page_match;
      logic ret_ready;
   } cell_stat_type;

endpackage

// File: hw/rtl/opfrs_cell.sv
// ----------------------------------------------------------------------------
// opfrs_cell: one queue slot of the request scheduler
// Holds one request, takes its neighbor's request when the head retires and
// reports issue and return eligibility to the scheduler.
// ----------------------------------------------------------------------------
module opfrs_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  opfrs_pkg::cell_cmd_type             cmd,
   input  opfrs_pkg::entry_type                new_entry,
   input  logic                                nbr_valid,
   input  opfrs_pkg::entry_type                nbr_entry,
   input  logic [opfrs_pkg::TIME_WIDTH-1:0]    issue_finish,
   input  logic [opfrs_pkg::TIME_WIDTH-1:0]    now,
   input  logic [opfrs_pkg::PAGE_WIDTH-1:0]    last_page,
   output logic                                valid,
   output opfrs_pkg::entry_type                entry,
   output opfrs_pkg::cell_stat_type            stat
);

   logic                 valid_ff, valid_in;
   opfrs_pkg::entry_type entry_ff, entry_in;
   logic [opfrs_pkg::TIME_WIDTH-1:0] age;

   // pick the slot's next content
   always_comb begin
      valid_in = valid_ff;
      entry_in = entry_ff;
      if (cmd.load) begin
         valid_in = 1'b1;
         entry_in = new_entry;
      end else if (cmd.shift) begin
         valid_in = nbr_valid;
         entry_in = nbr_entry;
      end else begin
         if (cmd.issue) begin
            entry_in.started = 1'b1;
            entry_in.finish  = issue_finish;
         end
         if (cmd.mark_ret) begin
            entry_in.returned = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // eligibility flags; finish counts as reached within half the time range
   assign age              = now - entry_ff.finish;
   assign stat.unstarted   = valid_ff && !entry_ff.started;
   assign stat.page_match  =
      (entry_ff.addr[opfrs_pkg::ADDR_WIDTH-1:opfrs_pkg::PAGE_BITS] == last_page);
   assign stat.ret_ready   = valid_ff && entry_ff.started && !entry_ff.returned &&
                             !age[opfrs_pkg::TIME_WIDTH-1];
   assign valid            = valid_ff;
   assign entry            = entry_ff;

endmodule

// File: hw/rtl/open_page_first_request_scheduler.sv
// ----------------------------------------------------------------------------
// open_page_first_request_scheduler: open-page first memory request scheduler
// A row of queue cells, oldest at cell 0, with a sequencer that issues,
// returns and retires requests on working ticks.
// ----------------------------------------------------------------------------
// Sequence: an enqueue or an idle tick passes through issue and retire before
// its response posts; a working tick with requests held runs issue scan, return
// scan, head retire and post.
// A new request is taken only in the idle state, after the last one has posted
// its response; the next request is taken while a response waits, and the retire
// step holds until that response is taken.
// Reset: synchronous, clears cell valid flags, state, count, page, time, phase, response valid and config registers.
module open_page_first_request_scheduler (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // req_addr, requester_tag, has_requester, is_prefetch, line_size,
   // dram_latency, bus_idle, zero fill
   input  logic [opfrs_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,
   // operation
   input  logic                                     req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // enqueue_rejected, issued, issued_addr, returned, returned_tag,
   // returned_prefetch, returned_line_size, queue_count, zero fill
   output logic [opfrs_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata,
   input  logic                                     csr_we,
   input  logic [opfrs_pkg::CSR_ADDR_WIDTH-1:0]     csr_addr,
   input  logic [opfrs_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   localparam int DEPTH = opfrs_pkg::QUEUE_DEPTH;
   localparam int TW    = opfrs_pkg::TIME_WIDTH;
   localparam int CW    = opfrs_pkg::COUNT_WIDTH;

   opfrs_pkg::sched_state_type state_ff, state_in;

   logic                         fifo_mode_ff;
   logic [opfrs_pkg::RATIO_WIDTH-1:0] clock_ratio_ff, ratio;
   logic [opfrs_pkg::RATIO_WIDTH:0]   phase_next;

   // captured request
   logic                         op_ff;
   opfrs_pkg::entry_type         item_ff;
   logic [opfrs_pkg::LAT_WIDTH-1:0] lat_ff;
   logic                         bus_ff;
   logic                         working_ff, working_in;

   logic [CW-1:0]                count_ff, count_in;
   logic [opfrs_pkg::PAGE_WIDTH-1:0] last_page_ff, last_page_in;
   logic [TW-1:0]                next_issue_ff, next_issue_in;
   logic [TW-1:0]                cycle_ff, cycle_in, gate_age;
   logic [opfrs_pkg::RATIO_WIDTH-1:0] phase_ff, phase_in;

   // response fields being built
   logic                         rej_ff, rej_in;
   logic                         iss_ff, iss_in;
   logic [opfrs_pkg::ADDR_WIDTH-1:0] iss_addr_ff, iss_addr_in;
   logic                         ret_ff, ret_in;
   logic [opfrs_pkg::TAG_WIDTH-1:0] ret_tag_ff, ret_tag_in;
   logic                         ret_pf_ff, ret_pf_in;
   logic [opfrs_pkg::LS_WIDTH-1:0]  ret_ls_ff, ret_ls_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [opfrs_pkg::RSP_TDATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   opfrs_pkg::cell_cmd_type      cmd      [DEPTH];
   opfrs_pkg::entry_type         cell_ent [DEPTH];
   opfrs_pkg::cell_stat_type     cell_st  [DEPTH];
   logic [DEPTH-1:0]             cell_vld;
   logic [DEPTH-1:0]             valid_mask;
   logic [TW-1:0]                issue_finish;

   logic                         accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == opfrs_pkg::ST_IDLE);
   assign ratio      = (clock_ratio_ff == '0) ? opfrs_pkg::RATIO_WIDTH'(1) : clock_ratio_ff;
   assign phase_next = {1'b0, phase_ff} + (opfrs_pkg::RATIO_WIDTH + 1)'(1);
   assign issue_finish = cycle_ff + TW'(lat_ff);
   assign gate_age   = cycle_ff - next_issue_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_mode_ff   <= 1'b0;
         clock_ratio_ff <= opfrs_pkg::RATIO_WIDTH'(1);
      end else if (csr_we) begin
         unique case (csr_addr)
            opfrs_pkg::CSR_FIFO_MODE:   fifo_mode_ff   <= csr_wdata[0];
            opfrs_pkg::CSR_CLOCK_RATIO: clock_ratio_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // capture the accepted request
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff             <= req_tuser;
         item_ff.addr      <= req_tdata[opfrs_pkg::ADDR_WIDTH-1:0];
         item_ff.tag       <= req_tdata[opfrs_pkg::REQ_TAG_LSB +: opfrs_pkg::TAG_WIDTH];
         item_ff.has_req   <= req_tdata[opfrs_pkg::REQ_HAS_BIT];
         item_ff.prefetch  <= req_tdata[opfrs_pkg::REQ_PF_BIT];
         item_ff.line_size <= req_tdata[opfrs_pkg::REQ_LS_LSB +: opfrs_pkg::LS_WIDTH];
         item_ff.started   <= 1'b0;
         item_ff.returned  <= 1'b0;
         item_ff.finish    <= '0;
         lat_ff            <= req_tdata[opfrs_pkg::REQ_LAT_LSB +: opfrs_pkg::LAT_WIDTH];
         bus_ff            <= req_tdata[opfrs_pkg::REQ_BUS_BIT];
      end
   end

   // the cell row; each cell takes its upper neighbor on a retire
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_last
         opfrs_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .cmd          (cmd[g]),
            .new_entry    (item_ff),
            .nbr_valid    (1'b0),
            .nbr_entry    (item_ff),
            .issue_finish (issue_finish),
            .now          (cycle_ff),
            .last_page    (last_page_ff),
            .valid        (cell_vld[g]),
            .entry        (cell_ent[g]),
            .stat         (cell_st[g])
         );
      end else begin : g_mid
         opfrs_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .cmd          (cmd[g]),
            .new_entry    (item_ff),
            .nbr_valid    (cell_vld[g+1]),
            .nbr_entry    (cell_ent[g+1]),
            .issue_finish (issue_finish),
            .now          (cycle_ff),
            .last_page    (last_page_ff),
            .valid        (cell_vld[g]),
            .entry        (cell_ent[g]),
            .stat         (cell_st[g])
         );
      end
   end

   // sequencer: enqueue, issue scan, return scan, head retire and response post
   always_comb begin
      logic           seen_u, seen_m, stop;
      logic [DEPTH-1:0] oh_u, oh_m, sel;
      logic [opfrs_pkg::RSP_TDATA_WIDTH-1:0] pack;

      state_in      = state_ff;
      count_in      = count_ff;
      last_page_in  = last_page_ff;
      next_issue_in = next_issue_ff;
      cycle_in      = cycle_ff;
      phase_in      = phase_ff;
      working_in    = working_ff;
      rej_in        = rej_ff;
      iss_in        = iss_ff;
      iss_addr_in   = iss_addr_ff;
      ret_in        = ret_ff;
      ret_tag_in    = ret_tag_ff;
      ret_pf_in     = ret_pf_ff;
      ret_ls_in     = ret_ls_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      seen_u = 1'b0;
      seen_m = 1'b0;
      stop   = 1'b0;
      oh_u   = '0;
      oh_m   = '0;
      sel    = '0;
      pack   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         cmd[i] = '0;
      end

      unique case (state_ff)
         opfrs_pkg::ST_IDLE: begin
            if (accept) begin
               working_in = (phase_ff == '0);
               rej_in     = 1'b0;
               iss_in     = 1'b0;
               iss_addr_in = '0;
               ret_in     = 1'b0;
               ret_tag_in = '0;
               ret_pf_in  = 1'b0;
               ret_ls_in  = '0;
               state_in   = opfrs_pkg::ST_ISSUE;
            end
         end
         opfrs_pkg::ST_ISSUE: begin
            if (op_ff == opfrs_pkg::OP_ENQUEUE) begin
               // append at the first free cell, or reject when full
               if (count_ff == CW'(DEPTH)) begin
                  rej_in = 1'b1;
               end else begin
                  for (int i = 0; i < DEPTH; i++) begin
                     cmd[i].load = (count_ff == CW'(i));
                  end
                  count_in = count_ff + CW'(1);
               end
               state_in = opfrs_pkg::ST_RETIRE;
            end else begin
               phase_in = (phase_next >= {1'b0, ratio}) ? '0 : phase_next[opfrs_pkg::RATIO_WIDTH-1:0];
               if (working_ff && count_ff != '0) begin
                  // oldest unstarted, and oldest unstarted on the open page
                  for (int i = 0; i < DEPTH; i++) begin
                     oh_u[i] = cell_st[i].unstarted && !seen_u;
                     oh_m[i] = cell_st[i].unstarted && cell_st[i].page_match && !seen_m;
                     seen_u  = seen_u || cell_st[i].unstarted;
                     seen_m  = seen_m || (cell_st[i].unstarted && cell_st[i].page_match);
                  end
                  sel = (seen_m && !fifo_mode_ff) ? oh_m : oh_u;
                  if (seen_u && !gate_age[TW-1]) begin
                     for (int i = 0; i < DEPTH; i++) begin
                        cmd[i].issue = sel[i];
                        if (sel[i]) begin
                           iss_addr_in = cell_ent[i].addr;
                        end
                     end
                     iss_in        = 1'b1;
                     last_page_in  =
                        iss_addr_in[opfrs_pkg::ADDR_WIDTH-1:opfrs_pkg::PAGE_BITS];
                     next_issue_in = cycle_ff + TW'(ratio);
                  end
                  state_in = opfrs_pkg::ST_RETURN;
               end else begin
                  state_in = opfrs_pkg::ST_RETIRE;
               end
            end
         end
         opfrs_pkg::ST_RETURN: begin
            // return the first finished fill if the bus is idle; drop silent ones ahead of it
            for (int i = 0; i < DEPTH; i++) begin
               if (cell_st[i].ret_ready && !stop) begin
                  if (!cell_ent[i].has_req) begin
                     cmd[i].mark_ret = 1'b1;
                  end else if (bus_ff) begin
                     cmd[i].mark_ret = 1'b1;
                     ret_in     = 1'b1;
                     ret_tag_in = cell_ent[i].tag;
                     ret_pf_in  = cell_ent[i].prefetch;
                     ret_ls_in  = cell_ent[i].line_size;
                     stop       = 1'b1;
                  end
               end
            end
            state_in = opfrs_pkg::ST_RETIRE;
         end
         opfrs_pkg::ST_RETIRE: begin
            // hold until the previous response is taken
            if (!rsp_valid_ff || rsp_tready) begin
               // advance the tick count, retire a returned head, post the response
               if (op_ff == opfrs_pkg::OP_TICK) begin
                  cycle_in = cycle_ff + TW'(1);
               end
               if (op_ff == opfrs_pkg::OP_TICK && working_ff &&
                   cell_vld[0] && cell_ent[0].returned) begin
                  for (int i = 0; i < DEPTH; i++) begin
                     cmd[i].shift = 1'b1;
                  end
                  count_in = count_ff - CW'(1);
               end
               pack[0]                                          = rej_ff;
               pack[opfrs_pkg::RSP_ISS_BIT]                     = iss_ff;
               pack[opfrs_pkg::RSP_ADDR_LSB +: opfrs_pkg::ADDR_WIDTH] = iss_addr_ff;
               pack[opfrs_pkg::RSP_RET_BIT]                     = ret_ff;
               pack[opfrs_pkg::RSP_TAG_LSB +: opfrs_pkg::TAG_WIDTH] = ret_tag_ff;
               pack[opfrs_pkg::RSP_PF_BIT]                      = ret_pf_ff;
               pack[opfrs_pkg::RSP_LS_LSB +: opfrs_pkg::LS_WIDTH] = ret_ls_ff;
               pack[opfrs_pkg::RSP_CNT_LSB +: CW]               = count_in;
               rsp_data_in  = pack;
               rsp_valid_in = 1'b1;
               state_in     = opfrs_pkg::ST_IDLE;
            end
         end
         default: state_in = opfrs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= opfrs_pkg::ST_IDLE;
         count_ff      <= '0;
         last_page_ff  <= '0;
         next_issue_ff <= '0;
         cycle_ff      <= '0;
         phase_ff      <= '0;
         working_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         last_page_ff  <= last_page_in;
         next_issue_ff <= next_issue_in;
         cycle_ff      <= cycle_in;
         phase_ff      <= phase_in;
         working_ff    <= working_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rej_ff      <= rej_in;
      iss_ff      <= iss_in;
      iss_addr_ff <= iss_addr_in;
      ret_ff      <= ret_in;
      ret_tag_ff  <= ret_tag_in;
      ret_pf_ff   <= ret_pf_in;
      ret_ls_ff   <= ret_ls_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // occupied cells form a prefix of the row
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid_mask[i] = (count_ff > CW'(i));
      end
   end

   a_cells_packed: assert property (@(posedge clock) disable iff (reset)
      cell_vld == valid_mask)
      else $error("occupied cells do not match the held count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("held count above queue depth");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("waiting response dropped or changed");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (state_ff == opfrs_pkg::ST_ISSUE && op_ff == opfrs_pkg::OP_ENQUEUE &&
       count_ff == CW'(DEPTH)) |=> rej_ff && count_ff == CW'(DEPTH))
      else $error("enqueue on a full queue not rejected");

endmodule
